### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

### hw/rtl/obb_pkg.sv
// ----------------------------------------------------------------------------
// OBB separating-axis test package
// Widths, command and term types, and the per-axis term table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package obb_pkg;

  localparam int AXIS_FRAC_BITS = 14;

  localparam int AXIS_W  = 16;
  localparam int EXT_W   = 31;
  localparam int CTR_W   = 32;
  localparam int EPS_W   = 15;
  localparam int DIFF_W  = 33;
  localparam int ROT_W   = 19;
  localparam int AROT_W  = 18;
  localparam int TV_W    = 37;
  localparam int ACC_W   = 46;
  localparam int MA_W    = 38;
  localparam int MB_W    = 19;
  localparam int PROD_W  = MA_W + MB_W;

  localparam int BOX_ROWS  = 3;
  localparam int EXT_DEPTH = 2 * BOX_ROWS;
  localparam int ROT_DEPTH = BOX_ROWS * BOX_ROWS;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);
  localparam logic [1:0] ROW_NONE = 2'd3;
  localparam logic [3:0] SEP_NONE = 4'd15;
  localparam logic [3:0] LAST_AXIS = 4'd14;
  localparam logic [3:0] FACE_A_END = 4'd3;
  localparam logic [3:0] FACE_B_END = 4'd6;
  localparam logic [2:0] TERM_FIRST = 3'd1;
  localparam logic [2:0] TERM_CMP = 3'd7;
  localparam logic signed [ACC_W-1:0] T_LIMIT = ACC_W'(64'sd68719476735);

  typedef logic signed [AXIS_W-1:0] axis_t;

  typedef struct packed {
    logic              load;
    logic              run;
    logic              box;
    logic [1:0]        row;
    axis_t             ax;
    axis_t             ay;
    axis_t             az;
    logic [EXT_W-1:0]  ext;
    logic [CTR_W-1:0]  ctr;
  } cmd_t;

  typedef struct packed {
    logic       valid;
    logic       is_p;
    logic       neg;
    logic [2:0] a_idx;
    logic [1:0] r;
    logic [1:0] c;
  } term_t;

  function automatic logic [1:0] inc3(input logic [1:0] x);
    return (x == 2'd2) ? 2'd0 : x + 2'd1;
  endfunction

  function automatic logic [3:0] ri9(input logic [1:0] r, input logic [1:0] c);
    return (4'(r) << 1) + 4'(r) + 4'(c);
  endfunction

  function automatic term_t mk_term(input logic p, input logic n, input logic [2:0] a,
                                    input logic [1:0] r, input logic [1:0] c);
    term_t tt;
    tt.valid = 1'b1;
    tt.is_p  = p;
    tt.neg   = n;
    tt.a_idx = a;
    tt.r     = r;
    tt.c     = c;
    return tt;
  endfunction

  // ea/eb index a_idx: box*3+k; t index a_idx[1:0]
  function automatic term_t test_term(input logic [3:0] ax, input logic [2:0] q);
    term_t      tt;
    logic [3:0] m;
    logic [1:0] i, j, i1, i2, j1, j2, qq, jj;
    tt = '0;
    m  = ax - FACE_B_END;
    i  = (m >= 4'd6) ? 2'd2 : ((m >= 4'd3) ? 2'd1 : 2'd0);
    j  = 2'(m - ((4'(i) << 1) + 4'(i)));
    i1 = inc3(i);
    i2 = inc3(i1);
    j1 = inc3(j);
    j2 = inc3(j1);
    qq = 2'(q - 3'd3);
    jj = 2'(ax - FACE_A_END);
    if (ax < FACE_A_END) begin
      if (q < 3'd3) begin
        tt = mk_term(1'b0, 1'b0, 3'd3 + q, ax[1:0], q[1:0]);
      end
    end else if (ax < FACE_B_END) begin
      if (q < 3'd3) begin
        tt = mk_term(1'b0, 1'b0, q, q[1:0], jj);
      end else if (q < 3'd6) begin
        tt = mk_term(1'b1, 1'b0, {1'b0, qq}, qq, jj);
      end
    end else begin
      case (q)
        3'd0: tt = mk_term(1'b0, 1'b0, {1'b0, i1}, i2, j);
        3'd1: tt = mk_term(1'b0, 1'b0, {1'b0, i2}, i1, j);
        3'd2: tt = mk_term(1'b0, 1'b0, 3'd3 + 3'(j1), i, j2);
        3'd3: tt = mk_term(1'b0, 1'b0, 3'd3 + 3'(j2), i, j1);
        3'd4: tt = mk_term(1'b1, 1'b0, {1'b0, i2}, i1, j);
        3'd5: tt = mk_term(1'b1, 1'b1, {1'b0, i1}, i2, j);
        default: tt = '0;
      endcase
    end
    return tt;
  endfunction

endpackage

### hw/rtl/obb_front.sv
// ----------------------------------------------------------------------------
// OBB front end
// Accepts items, classifies them as load and/or run, and stages them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module obb_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          box_select,
  input  logic [1:0]                    row,
  input  logic signed [15:0]            axis_x,
  input  logic signed [15:0]            axis_y,
  input  logic signed [15:0]            axis_z,
  input  logic [30:0]                   half_extent,
  input  logic signed [31:0]            center_comp,
  input  logic                          last,
  input  logic                          q_ready,
  output logic                          q_push,
  output obb_pkg::cmd_t                 q_cmd
);

  logic          stage_v;
  obb_pkg::cmd_t stage;
  obb_pkg::cmd_t cls;
  logic          accept;

  always_comb begin
    cls.load = (row != obb_pkg::ROW_NONE);
    cls.run  = last;
    cls.box  = box_select;
    cls.row  = row;
    cls.ax   = axis_x;
    cls.ay   = axis_y;
    cls.az   = axis_z;
    cls.ext  = half_extent;
    cls.ctr  = center_comp;
  end

  assign busy   = stage_v && !q_ready;
  assign accept = start && !busy;
  assign q_push = stage_v && q_ready;
  assign q_cmd  = stage;

  // drop items that neither load nor run
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v <= 1'b0;
    end else if (accept) begin
      stage_v <= cls.load || cls.run;
    end else if (q_push) begin
      stage_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= cls;
    end
  end

endmodule

### hw/rtl/obb_queue.sv
// ----------------------------------------------------------------------------
// OBB command queue
// Short FIFO between the front end and the test engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module obb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  obb_pkg::cmd_t din,
  input  logic          pop,
  output obb_pkg::cmd_t dout,
  output logic          not_empty,
  output logic          ready
);

  obb_pkg::cmd_t                    mem [obb_pkg::Q_DEPTH];
  logic [obb_pkg::Q_PTR_W-1:0]      wptr;
  logic [obb_pkg::Q_PTR_W-1:0]      rptr;
  logic [obb_pkg::Q_CNT_W-1:0]      count;

  localparam logic [obb_pkg::Q_PTR_W-1:0] PTR_LAST = obb_pkg::Q_PTR_W'(obb_pkg::Q_DEPTH - 1);
  localparam logic [obb_pkg::Q_CNT_W-1:0] CNT_FULL = obb_pkg::Q_CNT_W'(obb_pkg::Q_DEPTH);

  assign not_empty = (count != '0);
  assign ready     = (count != CNT_FULL);
  assign dout      = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_LAST) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_LAST) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

endmodule

### hw/rtl/obb_back.sv
// ----------------------------------------------------------------------------
// OBB test engine
// Holds the box rows and runs the fifteen axis tests on one shared multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module obb_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [obb_pkg::EPS_W-1:0]   eps,
  input  logic                        q_valid,
  input  obb_pkg::cmd_t               q_cmd,
  output logic                        q_pop,
  output logic                        done,
  output logic                        hit,
  output logic [3:0]                  separating_axis
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIFF  = 5'b00010,
    S_ROT   = 5'b00100,
    S_TRANS = 5'b01000,
    S_TEST  = 5'b10000
  } state_t;

  state_t state;

  obb_pkg::axis_t                      axa [obb_pkg::BOX_ROWS][obb_pkg::BOX_ROWS];
  obb_pkg::axis_t                      axb [obb_pkg::BOX_ROWS][obb_pkg::BOX_ROWS];
  logic [obb_pkg::EXT_W-1:0]           ext [obb_pkg::EXT_DEPTH];
  logic signed [obb_pkg::CTR_W-1:0]    ctra [obb_pkg::BOX_ROWS];
  logic signed [obb_pkg::CTR_W-1:0]    ctrb [obb_pkg::BOX_ROWS];
  logic signed [obb_pkg::DIFF_W-1:0]   dv [obb_pkg::BOX_ROWS];
  logic signed [obb_pkg::ROT_W-1:0]    rot [obb_pkg::ROT_DEPTH];
  logic [obb_pkg::AROT_W-1:0]          arot [obb_pkg::ROT_DEPTH];
  logic signed [obb_pkg::TV_W-1:0]     tv [obb_pkg::BOX_ROWS];

  logic [1:0] ci, cj, ck;
  logic       ph;
  logic [3:0] ax;
  logic [2:0] q;

  logic signed [obb_pkg::PROD_W-1:0] prod;
  logic signed [obb_pkg::PROD_W-1:0] prod_next;
  logic signed [obb_pkg::MA_W-1:0]   op_a;
  logic signed [obb_pkg::MB_W-1:0]   op_b;
  logic signed [obb_pkg::ACC_W-1:0]  racc;
  logic signed [obb_pkg::ACC_W-1:0]  pacc;
  logic signed [obb_pkg::ACC_W-1:0]  term_v;
  logic signed [obb_pkg::ACC_W-1:0]  abs_p;
  logic signed [obb_pkg::ACC_W-1:0]  sat_p;
  logic signed [obb_pkg::ACC_W-1:0]  init_r;
  logic signed [obb_pkg::ACC_W-1:0]  init_p;

  obb_pkg::term_t              tm;
  logic [2:0]                  ext_idx;
  logic [1:0]                  tv_idx;
  logic [3:0]                  ridx;
  logic [obb_pkg::EXT_W-1:0]   ext_rd;
  logic                        sep_found;
  logic [2:0]                  ld_idx;

  assign q_pop  = (state == S_IDLE) && q_valid;
  assign ld_idx = 3'(q_cmd.row) + (q_cmd.box ? 3'd3 : 3'd0);

  assign tm      = obb_pkg::test_term(ax, q - 3'd1);
  assign ext_idx = (q == 3'd0) ? ax[2:0] : tm.a_idx;
  assign tv_idx  = (q == 3'd0) ? ax[1:0] : tm.a_idx[1:0];
  assign ridx    = obb_pkg::ri9(tm.r, tm.c);
  assign ext_rd  = ext[ext_idx];

  assign term_v    = obb_pkg::ACC_W'(prod >>> obb_pkg::AXIS_FRAC_BITS);
  assign abs_p     = pacc[obb_pkg::ACC_W-1] ? -pacc : pacc;
  assign sep_found = abs_p > racc;

  always_comb begin
    if (pacc > obb_pkg::T_LIMIT) begin
      sat_p = obb_pkg::T_LIMIT;
    end else if (pacc < -obb_pkg::T_LIMIT) begin
      sat_p = -obb_pkg::T_LIMIT;
    end else begin
      sat_p = pacc;
    end
  end

  always_comb begin
    init_r = '0;
    init_p = '0;
    if (ax < obb_pkg::FACE_B_END) begin
      init_r = obb_pkg::ACC_W'(ext_rd);
    end
    if (ax < obb_pkg::FACE_A_END) begin
      init_p = obb_pkg::ACC_W'(tv[tv_idx]);
    end
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      S_ROT: begin
        op_a = obb_pkg::MA_W'(axa[ci][ck]);
        op_b = obb_pkg::MB_W'(axb[cj][ck]);
      end
      S_TRANS: begin
        op_a = obb_pkg::MA_W'(dv[ck]);
        op_b = obb_pkg::MB_W'(axa[ci][ck]);
      end
      S_TEST: begin
        if (tm.is_p) begin
          op_a = obb_pkg::MA_W'(tv[tv_idx]);
          op_b = obb_pkg::MB_W'(rot[ridx]);
        end else begin
          op_a = obb_pkg::MA_W'(ext_rd);
          op_b = {1'b0, arot[ridx]};
        end
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_next = op_a * op_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      ci              <= '0;
      cj              <= '0;
      ck              <= '0;
      ph              <= 1'b0;
      ax              <= '0;
      q               <= '0;
      done            <= 1'b0;
      hit             <= 1'b0;
      separating_axis <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid && q_cmd.run) begin
            ck    <= '0;
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          if (ck == 2'd2) begin
            ck    <= '0;
            ci    <= '0;
            cj    <= '0;
            ph    <= 1'b0;
            state <= S_ROT;
          end else begin
            ck <= ck + 2'd1;
          end
        end
        S_ROT: begin
          if (ck == 2'd3) begin
            ck <= '0;
            if (cj == 2'd2) begin
              cj <= '0;
              if (ci == 2'd2) begin
                ci    <= '0;
                state <= S_TRANS;
              end else begin
                ci <= ci + 2'd1;
              end
            end else begin
              cj <= cj + 2'd1;
            end
          end else if (ph) begin
            ph <= 1'b0;
            ck <= ck + 2'd1;
          end else begin
            ph <= 1'b1;
          end
        end
        S_TRANS: begin
          if (ck == 2'd3) begin
            ck <= '0;
            if (ci == 2'd2) begin
              ax    <= '0;
              q     <= '0;
              state <= S_TEST;
            end else begin
              ci <= ci + 2'd1;
            end
          end else if (ph) begin
            ph <= 1'b0;
            ck <= ck + 2'd1;
          end else begin
            ph <= 1'b1;
          end
        end
        S_TEST: begin
          if (q == 3'd0) begin
            q <= obb_pkg::TERM_FIRST;
          end else if (q == obb_pkg::TERM_CMP) begin
            if (sep_found) begin
              done            <= 1'b1;
              hit             <= 1'b0;
              separating_axis <= ax;
              state           <= S_IDLE;
            end else if (ax == obb_pkg::LAST_AXIS) begin
              done            <= 1'b1;
              hit             <= 1'b1;
              separating_axis <= obb_pkg::SEP_NONE;
              state           <= S_IDLE;
            end else begin
              ax <= ax + 4'd1;
              q  <= '0;
            end
          end else if (!tm.valid) begin
            q <= q + 3'd1;
          end else if (ph) begin
            ph <= 1'b0;
            q  <= q + 3'd1;
          end else begin
            ph <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
    if (q_pop && q_cmd.load) begin
      if (q_cmd.box) begin
        axb[q_cmd.row] <= '{q_cmd.ax, q_cmd.ay, q_cmd.az};
        ctrb[q_cmd.row] <= q_cmd.ctr;
      end else begin
        axa[q_cmd.row] <= '{q_cmd.ax, q_cmd.ay, q_cmd.az};
        ctra[q_cmd.row] <= q_cmd.ctr;
      end
      ext[ld_idx] <= q_cmd.ext;
    end
    case (state)
      S_DIFF: begin
        dv[ck] <= obb_pkg::DIFF_W'(ctrb[ck]) - obb_pkg::DIFF_W'(ctra[ck]);
        pacc   <= '0;
      end
      S_ROT: begin
        if (ck == 2'd3) begin
          rot[obb_pkg::ri9(ci, cj)]  <= obb_pkg::ROT_W'(pacc);
          arot[obb_pkg::ri9(ci, cj)] <= obb_pkg::AROT_W'(abs_p) + obb_pkg::AROT_W'(eps);
          pacc <= '0;
        end else if (ph) begin
          pacc <= pacc + term_v;
        end
      end
      S_TRANS: begin
        if (ck == 2'd3) begin
          tv[ci] <= obb_pkg::TV_W'(sat_p);
          pacc   <= '0;
        end else if (ph) begin
          pacc <= pacc + term_v;
        end
      end
      S_TEST: begin
        if (q == 3'd0) begin
          racc <= init_r;
          pacc <= init_p;
        end else if (q != obb_pkg::TERM_CMP && tm.valid && ph) begin
          if (!tm.is_p) begin
            racc <= racc + term_v;
          end else if (tm.neg) begin
            pacc <= pacc - term_v;
          end else begin
            pacc <= pacc + term_v;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### hw/rtl/obb_separating_axis_test_top.sv
// ----------------------------------------------------------------------------
// OBB separating-axis test, top level
// Load items are accepted back to back while the engine is idle.
// A run item accepted with the engine idle computes 27 rotation, 9 translation
// and up to 81 test products, plus a setup and a compare step per axis, all
// through one shared 38x19 multiplier in the test engine.
// Reset clears control state and sets epsilon to 1; box rows stay undefined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module obb_separating_axis_test_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        box_select,
  input  logic [1:0]                  row,
  input  logic signed [15:0]          axis_x,
  input  logic signed [15:0]          axis_y,
  input  logic signed [15:0]          axis_z,
  input  logic [30:0]                 half_extent,
  input  logic signed [31:0]          center_comp,
  input  logic                        last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [obb_pkg::EPS_W-1:0]   epsilon,
  output logic                        done,
  output logic                        hit,
  output logic [3:0]                  separating_axis
);

  logic [obb_pkg::EPS_W-1:0] eps;
  logic                      q_push;
  logic                      q_pop;
  logic                      q_ready;
  logic                      q_valid;
  obb_pkg::cmd_t             f_cmd;
  obb_pkg::cmd_t             q_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= obb_pkg::EPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      eps <= epsilon;
    end
  end

  obb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .box_select  (box_select),
    .row         (row),
    .axis_x      (axis_x),
    .axis_y      (axis_y),
    .axis_z      (axis_z),
    .half_extent (half_extent),
    .center_comp (center_comp),
    .last        (last),
    .q_ready     (q_ready),
    .q_push      (q_push),
    .q_cmd       (f_cmd)
  );

  obb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .din       (f_cmd),
    .pop       (q_pop),
    .dout      (q_cmd),
    .not_empty (q_valid),
    .ready     (q_ready)
  );

  obb_back u_back (
    .clk             (clk),
    .rst             (rst),
    .eps             (eps),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_pop           (q_pop),
    .done            (done),
    .hit             (hit),
    .separating_axis (separating_axis)
  );

  `ASSERT_PROP(a_hit_code, clk, rst, done |-> (hit == (separating_axis == obb_pkg::SEP_NONE)), "hit and axis code disagree")
  `ASSERT_NEVER(a_q_overflow, clk, rst, q_push && !q_ready, "command queue written while full")
  `ASSERT_NEVER(a_q_underflow, clk, rst, q_pop && !q_valid, "command queue read while empty")
  `ASSERT_PROP(a_done_pulse, clk, rst, done |=> !done, "result strobe held over two cycles")

endmodule

### tb/sv/tb_obb_separating_axis_test_top.sv
// ----------------------------------------------------------------------------
// OBB separating-axis test bench
// Loads box rows, runs the 15-axis overlap test and compares each result
// with a cycle-free predictor of hit and the first separating axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_obb_separating_axis_test_top;

  typedef struct {
    logic               box;
    logic [1:0]         row;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic [30:0]        ext;
    logic signed [31:0] ctr;
    logic               last;
  } box_row_t;

  typedef struct {
    logic       hit;
    logic [3:0] sep;
  } overlap_t;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic                      box_select;
  logic [1:0]                row;
  logic signed [15:0]        axis_x;
  logic signed [15:0]        axis_y;
  logic signed [15:0]        axis_z;
  logic [30:0]               half_extent;
  logic signed [31:0]        center_comp;
  logic                      last;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [obb_pkg::EPS_W-1:0] epsilon;
  logic                      done;
  logic                      hit;
  logic [3:0]                separating_axis;

  longint      axis_mem[2][3][3];
  longint      extent_mem[6];
  longint      center_mem[6];
  bit          row_loaded[6];
  longint      eps_val;
  overlap_t    overlap_q[$];
  int          mismatches;
  int          cycles;

  obb_separating_axis_test_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .box_select(box_select), .row(row), .axis_x(axis_x), .axis_y(axis_y),
    .axis_z(axis_z), .half_extent(half_extent), .center_comp(center_comp),
    .last(last), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .epsilon(epsilon), .done(done), .hit(hit), .separating_axis(separating_axis)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint abs_l(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint fs(longint v);
    return v >>> obb_pkg::AXIS_FRAC_BITS;
  endfunction

  function automatic logic all_loaded();
    foreach (row_loaded[i]) if (!row_loaded[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [3:0] find_separation();
    longint rot[3][3], arot[3][3], tv[3], dv[3], ea[3], eb[3];
    longint s, ra, rb, p;
    int i1, i2, j1, j2;
    for (int i = 0; i < 3; i++) begin
      ea[i] = extent_mem[i];
      eb[i] = extent_mem[3 + i];
      dv[i] = center_mem[3 + i] - center_mem[i];
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        s = 0;
        for (int k = 0; k < 3; k++) s += fs(axis_mem[0][i][k] * axis_mem[1][j][k]);
        rot[i][j] = s;
        arot[i][j] = abs_l(s) + eps_val;
      end
    for (int i = 0; i < 3; i++) begin
      s = 0;
      for (int k = 0; k < 3; k++) s += fs(dv[k] * axis_mem[0][i][k]);
      if (s > 64'sd68719476735) s = 64'sd68719476735;
      if (s < -64'sd68719476735) s = -64'sd68719476735;
      tv[i] = s;
    end
    for (int i = 0; i < 3; i++) begin
      rb = 0;
      for (int k = 0; k < 3; k++) rb += fs(eb[k] * arot[i][k]);
      if (abs_l(tv[i]) > ea[i] + rb) return 4'(i);
    end
    for (int j = 0; j < 3; j++) begin
      ra = 0;
      p = 0;
      for (int k = 0; k < 3; k++) begin
        ra += fs(ea[k] * arot[k][j]);
        p += fs(tv[k] * rot[k][j]);
      end
      if (abs_l(p) > ra + eb[j]) return 4'(3 + j);
    end
    for (int i = 0; i < 3; i++) begin
      i1 = (i + 1) % 3;
      i2 = (i + 2) % 3;
      for (int j = 0; j < 3; j++) begin
        j1 = (j + 1) % 3;
        j2 = (j + 2) % 3;
        ra = fs(ea[i1] * arot[i2][j]) + fs(ea[i2] * arot[i1][j]);
        rb = fs(eb[j1] * arot[i][j2]) + fs(eb[j2] * arot[i][j1]);
        p = fs(tv[i2] * rot[i1][j]) - fs(tv[i1] * rot[i2][j]);
        if (abs_l(p) > ra + rb) return 4'(6 + i * 3 + j);
      end
    end
    return obb_pkg::SEP_NONE;
  endfunction

  function automatic void apply_row(box_row_t it);
    overlap_t o;
    int e;
    if (it.row != obb_pkg::ROW_NONE) begin
      e = it.box * 3 + it.row;
      axis_mem[it.box][it.row][0] = it.ax;
      axis_mem[it.box][it.row][1] = it.ay;
      axis_mem[it.box][it.row][2] = it.az;
      extent_mem[e] = longint'(it.ext);
      center_mem[e] = longint'(it.ctr);
      row_loaded[e] = 1'b1;
    end
    if (it.last) begin
      o.sep = find_separation();
      o.hit = (o.sep == obb_pkg::SEP_NONE);
      overlap_q.push_back(o);
    end
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report(string what);
    $display("MISMATCH at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  task automatic send_row(box_row_t it, int gap);
    start       <= 1'b1;
    box_select  <= it.box;
    row         <= it.row;
    axis_x      <= it.ax;
    axis_y      <= it.ay;
    axis_z      <= it.az;
    half_extent <= it.ext;
    center_comp <= it.ctr;
    last        <= it.last;
    do @(posedge clk); while (busy);
    apply_row(it);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (overlap_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_epsilon(longint v);
    wait_idle();
    cfg_valid <= 1'b1;
    epsilon   <= obb_pkg::EPS_W'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    eps_val = v;
  endtask

  function automatic box_row_t make_row(logic b, logic [1:0] r, longint a0, longint a1,
                                        longint a2, longint e, longint c, logic l);
    box_row_t it;
    it.box = b; it.row = r;
    it.ax = 16'(a0); it.ay = 16'(a1); it.az = 16'(a2);
    it.ext = 31'(e); it.ctr = 32'(c); it.last = l;
    return it;
  endfunction

  task automatic load_boxes(longint ea, longint eb, longint ca[3], longint cb[3]);
    for (int b = 0; b < 2; b++)
      for (int r = 0; r < 3; r++)
        send_row(make_row(b[0], r[1:0], (r == 0) ? 16384 : 0, (r == 1) ? 16384 : 0,
                          (r == 2) ? 16384 : 0, b ? eb : ea, b ? cb[r] : ca[r],
                          1'b0), rand_gap());
  endtask

  task automatic test_directed();
    longint z3[3] = '{0, 0, 0};
    longint cx[3] = '{65536 * 5, 0, 0};
    longint cy[3] = '{0, -65536 * 5, 0};
    longint cz[3] = '{0, 0, 65536 * 5};
    load_boxes(65536, 65536, z3, z3);
    send_row(make_row(1, obb_pkg::ROW_NONE, 0, 0, 0, 0, 0, 1), 0);
    send_row(make_row(1, 0, 16384, 0, 0, 65536, cx[0], 1), 2);
    send_row(make_row(1, 0, 16384, 0, 0, 65536, 0, 0), 0);
    send_row(make_row(1, 1, 0, 16384, 0, 65536, cy[1], 1), 1);
    send_row(make_row(1, 1, 0, 16384, 0, 65536, 0, 0), 0);
    send_row(make_row(1, 2, 0, 0, 16384, 65536, cz[2], 1), 3);
    send_row(make_row(0, 0, -16384, 16384, -16384, 31'h7FFFFFFF, 32'sh7FFFFFFF, 0), 0);
    send_row(make_row(1, 0, 16384, -16384, 16384, 0, -2147483648, 1), 0);
    send_row(make_row(0, 1, 11585, 11585, 0, 0, -2147483648, 0), 0);
    send_row(make_row(1, 2, -11585, 0, 11585, 31'h7FFFFFFF, 32'sh7FFFFFFF, 1), 0);
    send_row(make_row(0, 2, 0, -11585, 11585, 65536, 0, 1), 5);
  endtask

  function automatic longint rand_axis_comp();
    return longint'($urandom_range(32768)) - 16384;
  endfunction

  task automatic test_random(int items);
    int sent, order[6], tmp, pick, nrows;
    box_row_t it;
    sent = 0;
    while (sent < items) begin
      foreach (order[i]) order[i] = i;
      for (int i = 5; i > 0; i--) begin
        pick = $urandom_range(i);
        tmp = order[i]; order[i] = order[pick]; order[pick] = tmp;
      end
      nrows = (all_loaded() && $urandom_range(3) == 0) ? $urandom_range(1, 3) : 6;
      for (int n = 0; n < nrows; n++) begin
        it.box = 1'(order[n] / 3);
        it.row = 2'(order[n] % 3);
        if ($urandom_range(1)) begin
          pick = $urandom_range(2);
          it.ax = 16'((pick == 0) ? ($urandom_range(1) ? 16384 : -16384) : 0);
          it.ay = 16'((pick == 1) ? ($urandom_range(1) ? 16384 : -16384) : 0);
          it.az = 16'((pick == 2) ? ($urandom_range(1) ? 16384 : -16384) : 0);
        end else begin
          it.ax = 16'(rand_axis_comp());
          it.ay = 16'(rand_axis_comp());
          it.az = 16'(rand_axis_comp());
        end
        it.ext = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(1 << 20));
        it.ctr = ($urandom_range(9) == 0) ? 32'($urandom)
                 : 32'(longint'($urandom_range(1 << 22)) - (1 << 21));
        it.last = (n == nrows - 1) && ($urandom_range(7) != 0);
        if ($urandom_range(15) == 0) begin
          box_row_t noise;
          noise = it;
          noise.row = obb_pkg::ROW_NONE;
          noise.last = all_loaded() && $urandom_range(1);
          send_row(noise, rand_gap());
        end
        send_row(it, (n == nrows - 1 || $urandom_range(3) != 0) ? rand_gap() : 0);
        sent++;
      end
      if (all_loaded() && $urandom_range(9) == 0) begin
        it.row = obb_pkg::ROW_NONE;
        it.last = 1'b1;
        send_row(it, rand_gap());
        sent++;
      end
      if ($urandom_range(19) == 0) begin
        start <= 1'b0;
        @(posedge clk);
        while (overlap_q.size() != 0) @(posedge clk);
      end
    end
  endtask

  task automatic test_epsilon_settings();
    write_epsilon(0);
    test_random(250);
    write_epsilon(16384);
    test_random(150);
    write_epsilon($urandom_range(16384));
    test_random(250);
    write_epsilon($urandom_range(64));
    test_random(250);
    write_epsilon(1);
    test_random(250);
  endtask

  always @(posedge clk) begin
    overlap_t exp_o;
    if (!rst && done) begin
      if (overlap_q.size() == 0) begin
        report("result with no expectation");
      end else begin
        exp_o = overlap_q.pop_front();
        if (hit !== exp_o.hit)
          report($sformatf("hit %0b, expected %0b", hit, exp_o.hit));
        if (separating_axis !== exp_o.sep)
          report($sformatf("separating_axis %0d, expected %0d", separating_axis, exp_o.sep));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    cycles = 0;
    mismatches = 0;
    eps_val = 1;
    foreach (row_loaded[i]) row_loaded[i] = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    box_select = 1'b0;
    row = '0;
    axis_x = '0;
    axis_y = '0;
    axis_z = '0;
    half_extent = '0;
    center_comp = '0;
    last = 1'b0;
    cfg_valid = 1'b0;
    epsilon = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_epsilon_settings();
    start <= 1'b0;
    @(posedge clk);
    while (overlap_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
